[rtl/tbfc_pkg.sv]
// ----------------------------------------------------------------------------
// Text block framer package
// Event codes, byte constants, the checksum label and the result beat type.
// ----------------------------------------------------------------------------
package tbfc_pkg;

    localparam int BYTE_W     = 8;
    localparam int COUNT_W    = 32;
    localparam int EVENT_W    = 4;
    localparam int KEY_LEN    = 8;
    localparam int LPOS_W     = 4;
    localparam int FIELDS_W   = 8;

    localparam logic [BYTE_W-1:0] BYTE_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] BYTE_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] BYTE_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] BYTE_COLON = 8'h3A;

    localparam logic [LPOS_W-1:0]   LPOS_MAX   = 4'd15;
    localparam logic [FIELDS_W-1:0] FIELDS_MAX = 8'd255;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE      = 4'd0,
        EV_LABEL     = 4'd1,
        EV_LABEL_END = 4'd2,
        EV_VALUE     = 4'd3,
        EV_FIELD_END = 4'd4,
        EV_GOOD      = 4'd5,
        EV_BAD       = 4'd6,
        EV_HEX       = 4'd7,
        EV_HEX_END   = 4'd8,
        EV_RUNT      = 4'd9
    } event_t;

    typedef struct packed {
        event_t               event_res;
        logic [BYTE_W-1:0]    data_byte;
        logic [COUNT_W-1:0]   runt_count;
        logic [COUNT_W-1:0]   checksum_error_count;
        logic [COUNT_W-1:0]   block_count;
        logic [COUNT_W-1:0]   field_count;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

    // Letters of the label "Checksum"
    function automatic logic [BYTE_W-1:0] key_byte(input logic [2:0] idx);
        logic [BYTE_W-1:0] ch;
        case (idx)
            3'd0: ch = 8'h43;
            3'd1: ch = 8'h68;
            3'd2: ch = 8'h65;
            3'd3: ch = 8'h63;
            3'd4: ch = 8'h6B;
            3'd5: ch = 8'h73;
            3'd6: ch = 8'h75;
            3'd7: ch = 8'h6D;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

[rtl/tbfc_parse.sv]
// ----------------------------------------------------------------------------
// Text block framer parser
// Holds the framing state and counters, and forms one result beat from each
// accepted byte in a single pass.
// ----------------------------------------------------------------------------
module tbfc_parse (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          accept,
    input  logic [tbfc_pkg::BYTE_W-1:0]   rx_byte,
    input  logic [tbfc_pkg::BYTE_W-1:0]   checksum_target,
    output tbfc_pkg::result_t             result
);
    import tbfc_pkg::*;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_RUNT  = 3'd1,
        MODE_START = 3'd2,
        MODE_LABEL = 3'd3,
        MODE_VALUE = 3'd4,
        MODE_CSUM  = 3'd5,
        MODE_HEX   = 3'd6
    } mode_t;

    mode_t                 mode_reg, mode_next;
    logic [BYTE_W-1:0]     sum_reg, sum_next;
    logic [LPOS_W-1:0]     lpos_reg, lpos_next;
    logic                  lmatch_reg, lmatch_next;
    logic [FIELDS_W-1:0]   fields_reg, fields_next;
    logic [COUNT_W-1:0]    runt_reg, runt_next;
    logic [COUNT_W-1:0]    bad_reg, bad_next;
    logic [COUNT_W-1:0]    good_reg, good_next;
    logic [COUNT_W-1:0]    ftotal_reg, ftotal_next;
    event_t                ev;
    logic [BYTE_W-1:0]     sum_add;
    logic                  key_miss_cont;
    logic                  key_miss_first;

    assign sum_add        = sum_reg + rx_byte;
    assign key_miss_cont  = (lpos_reg >= LPOS_W'(KEY_LEN)) ||
                            (key_byte(lpos_reg[2:0]) != rx_byte);
    assign key_miss_first = (key_byte(3'd0) != rx_byte);

    always_comb begin
        mode_next   = mode_reg;
        sum_next    = sum_reg;
        lpos_next   = lpos_reg;
        lmatch_next = lmatch_reg;
        fields_next = fields_reg;
        runt_next   = runt_reg;
        bad_next    = bad_reg;
        good_next   = good_reg;
        ftotal_next = ftotal_reg;
        ev          = EV_NONE;
        case (mode_reg)
            MODE_RUNT: begin
                if (rx_byte == BYTE_COLON) begin
                    mode_next = MODE_HEX;
                    ev        = EV_HEX;
                end else if (rx_byte == BYTE_LF) begin
                    sum_next    = rx_byte;
                    fields_next = '0;
                    mode_next   = MODE_START;
                end
            end
            MODE_START: begin
                if (rx_byte == BYTE_COLON) begin
                    mode_next = MODE_HEX;
                    ev        = EV_HEX;
                end else begin
                    sum_next    = sum_add;
                    lpos_next   = LPOS_W'(1);
                    lmatch_next = !key_miss_first;
                    mode_next   = MODE_LABEL;
                    ev          = EV_LABEL;
                end
            end
            MODE_LABEL: begin
                sum_next = sum_add;
                if (rx_byte == BYTE_TAB) begin
                    if (lmatch_reg && lpos_reg == LPOS_W'(KEY_LEN)) begin
                        mode_next = MODE_CSUM;
                    end else begin
                        mode_next = MODE_VALUE;
                    end
                    ev = EV_LABEL_END;
                end else begin
                    if (key_miss_cont) begin
                        lmatch_next = 1'b0;
                    end
                    if (lpos_reg != LPOS_MAX) begin
                        lpos_next = lpos_reg + LPOS_W'(1);
                    end
                    ev = EV_LABEL;
                end
            end
            MODE_VALUE: begin
                sum_next = sum_add;
                if (rx_byte == BYTE_LF) begin
                    if (fields_reg != FIELDS_MAX) begin
                        fields_next = fields_reg + FIELDS_W'(1);
                    end
                    mode_next = MODE_START;
                    ev        = EV_FIELD_END;
                end else if (rx_byte != BYTE_CR) begin
                    ev = EV_VALUE;
                end
            end
            MODE_CSUM: begin
                if (sum_add == checksum_target) begin
                    good_next   = good_reg + COUNT_W'(1);
                    ftotal_next = ftotal_reg + COUNT_W'(fields_reg);
                    ev          = EV_GOOD;
                end else begin
                    bad_next = bad_reg + COUNT_W'(1);
                    ev       = EV_BAD;
                end
                sum_next  = '0;
                mode_next = MODE_IDLE;
            end
            MODE_HEX: begin
                if (rx_byte == BYTE_LF) begin
                    sum_next  = '0;
                    mode_next = MODE_IDLE;
                    ev        = EV_HEX_END;
                end else begin
                    ev = EV_HEX;
                end
            end
            default: begin
                if (rx_byte == BYTE_COLON) begin
                    mode_next = MODE_HEX;
                    ev        = EV_HEX;
                end else if (rx_byte == BYTE_LF) begin
                    sum_next    = sum_add;
                    fields_next = '0;
                    mode_next   = MODE_START;
                end else if (rx_byte == BYTE_CR) begin
                    sum_next  = sum_add;
                    mode_next = MODE_IDLE;
                end else begin
                    runt_next = runt_reg + COUNT_W'(1);
                    mode_next = MODE_RUNT;
                    ev        = EV_RUNT;
                end
            end
        endcase
    end

    always_comb begin
        result.event_res            = ev;
        result.data_byte            = rx_byte;
        result.runt_count           = runt_next;
        result.checksum_error_count = bad_next;
        result.block_count          = good_next;
        result.field_count          = ftotal_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            sum_reg    <= '0;
            lpos_reg   <= '0;
            lmatch_reg <= 1'b1;
            fields_reg <= '0;
            runt_reg   <= '0;
            bad_reg    <= '0;
            good_reg   <= '0;
            ftotal_reg <= '0;
        end else if (accept) begin
            mode_reg   <= mode_next;
            sum_reg    <= sum_next;
            lpos_reg   <= lpos_next;
            lmatch_reg <= lmatch_next;
            fields_reg <= fields_next;
            runt_reg   <= runt_next;
            bad_reg    <= bad_next;
            good_reg   <= good_next;
            ftotal_reg <= ftotal_next;
        end
    end

`ifndef SYNTHESIS
    a_csum_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && mode_reg == MODE_CSUM) |=>
            ((good_reg != $past(good_reg)) || (bad_reg != $past(bad_reg))))
        else $error("checksum byte gave no verdict");

    a_runt_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ##1 ((runt_reg == $past(runt_reg)) || (runt_reg == $past(runt_reg) + COUNT_W'(1))))
        else $error("runt counter jumped");

    a_hex_end_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && mode_reg == MODE_HEX && rx_byte == BYTE_LF) |=>
            (sum_reg == '0 && mode_reg == MODE_IDLE))
        else $error("hex frame end left sum or mode");

    a_label_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_CSUM) |-> (lpos_reg == LPOS_W'(KEY_LEN) && lmatch_reg))
        else $error("checksum mode without matching label");
`endif

endmodule

[rtl/tbfc_outbuf.sv]
// ----------------------------------------------------------------------------
// Text block framer result buffer
// Output register with a skid stage so the input side keeps running while a
// result beat waits.
// ----------------------------------------------------------------------------
module tbfc_outbuf (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  tbfc_pkg::result_t    in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output tbfc_pkg::result_t    out_data
);
    import tbfc_pkg::*;

    logic    main_valid_reg;
    logic    skid_valid_reg;
    result_t main_reg;
    result_t skid_reg;
    logic    push;
    logic    pop;

    assign in_ready  = !skid_valid_reg;
    assign push      = in_valid && in_ready;
    assign pop       = main_valid_reg && out_ready;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (pop || !main_valid_reg) begin
            if (skid_valid_reg) begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                main_valid_reg <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop || !main_valid_reg) begin
            main_reg <= skid_valid_reg ? skid_reg : in_data;
        end else if (push) begin
            skid_reg <= in_data;
        end
    end

endmodule

[rtl/text_block_framer_checksum.sv]
// ----------------------------------------------------------------------------
// Text block framer with additive checksum
// Each result beat is registered in the output buffer, main or skid stage.
// Throughput: one byte per cycle while s_ready is high, set by the parser.
// A two-deep result buffer holds beats while the result side stalls.
// Reset: synchronous active-low aresetn clears mode, sum, counters, target.
// ----------------------------------------------------------------------------
module text_block_framer_checksum (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [tbfc_pkg::BYTE_W-1:0]    cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [tbfc_pkg::BYTE_W-1:0]    s_rx_byte,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [tbfc_pkg::EVENT_W-1:0]   m_event_res,
    output logic [tbfc_pkg::BYTE_W-1:0]    m_data_byte,
    output logic [tbfc_pkg::COUNT_W-1:0]   m_runt_count,
    output logic [tbfc_pkg::COUNT_W-1:0]   m_checksum_error_count,
    output logic [tbfc_pkg::COUNT_W-1:0]   m_block_count,
    output logic [tbfc_pkg::COUNT_W-1:0]   m_field_count
);
    import tbfc_pkg::*;

    logic [BYTE_W-1:0] target_reg;
    logic              accept;
    result_t           parse_result;
    result_t           out_beat;

    assign accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= '0;
        end else if (cfg_wr_en) begin
            target_reg <= cfg_wr_data;
        end
    end

    tbfc_parse u_parse (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .accept          (accept),
        .rx_byte         (s_rx_byte),
        .checksum_target (target_reg),
        .result          (parse_result)
    );

    tbfc_outbuf u_outbuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (parse_result),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_beat)
    );

    assign m_event_res            = out_beat.event_res;
    assign m_data_byte            = out_beat.data_byte;
    assign m_runt_count           = out_beat.runt_count;
    assign m_checksum_error_count = out_beat.checksum_error_count;
    assign m_block_count          = out_beat.block_count;
    assign m_field_count          = out_beat.field_count;

endmodule
